// ===== sv/dwpd_pkg.sv =====
// Package: shared widths, register codes and reset values for the PD drive block.
package dwpd_pkg;

	localparam int POS_W   = 21;
	localparam int ERR_W   = 23;
	localparam int GAIN_W  = 16;
	localparam int BAND_W  = 16;
	localparam int SLEW_W  = 15;
	localparam int DRV_W   = 16;
	localparam int CFG_W   = 21;
	localparam int IDX_W   = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_TARGET_DEG  = 3'd0,
		REG_KP_GAIN     = 3'd1,
		REG_KD_GAIN     = 3'd2,
		REG_DONE_BAND   = 3'd3,
		REG_SLEW_DROP   = 3'd4,
		REG_START_DRIVE = 3'd5
	} reg_idx_t;

	localparam logic signed [POS_W-1:0]  RST_TARGET_DEG  = '0;
	localparam logic [GAIN_W-1:0]        RST_KP_GAIN     = 16'd3277;
	localparam logic [GAIN_W-1:0]        RST_KD_GAIN     = 16'd6554;
	localparam logic [BAND_W-1:0]        RST_DONE_BAND   = 16'd13;
	localparam logic [SLEW_W-1:0]        RST_SLEW_DROP   = 15'd2560;
	localparam logic signed [DRV_W-1:0]  RST_START_DRIVE = 16'sd5120;

endpackage

// ===== sv/dwpd_if.sv =====
// Interfaces: input request channel and result channel with valid/ready handshake.
interface dwpd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 restart;
	logic signed [dwpd_pkg::POS_W-1:0]    left_pos_a;
	logic signed [dwpd_pkg::POS_W-1:0]    left_pos_b;
	logic signed [dwpd_pkg::POS_W-1:0]    left_pos_c;
	logic signed [dwpd_pkg::POS_W-1:0]    right_pos_a;
	logic signed [dwpd_pkg::POS_W-1:0]    right_pos_b;
	logic signed [dwpd_pkg::POS_W-1:0]    right_pos_c;

	modport source (
		output valid, restart, left_pos_a, left_pos_b, left_pos_c,
		       right_pos_a, right_pos_b, right_pos_c,
		input  ready
	);
	modport sink (
		input  valid, restart, left_pos_a, left_pos_b, left_pos_c,
		       right_pos_a, right_pos_b, right_pos_c,
		output ready
	);
endinterface

interface dwpd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dwpd_pkg::DRV_W-1:0]    left_drive;
	logic signed [dwpd_pkg::DRV_W-1:0]    right_drive;
	logic                                 done_res;

	modport source (
		output valid, left_drive, right_drive, done_res,
		input  ready
	);
	modport sink (
		input  valid, left_drive, right_drive, done_res,
		output ready
	);
endinterface

// ===== sv/dual_wheel_pd_drive_slew.sv =====
// Top level: two-sided PD drive controller with drop-rate limit and arrival latch.
// An accepted request passes through stage 1 and then the result register to out_ch.
// One request per cycle unless out_ch stalls; stage 1 holds the side errors, the result
// register holds the drives, and the controller state updates as a result is written.
// Reset (arst_n low) restores register defaults, clears both stages and the done latch,
// and presets the previous drives to the default start drive.
module dual_wheel_pd_drive_slew (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dwpd_pkg::IDX_W-1:0]         cfg_index,
	input  logic [dwpd_pkg::CFG_W-1:0]         cfg_data,
	dwpd_in_if.sink                            in_ch,
	dwpd_out_if.source                         out_ch
);
	// configuration registers
	logic signed [dwpd_pkg::POS_W-1:0]  target_deg_q;
	logic [dwpd_pkg::GAIN_W-1:0]        kp_gain_q;
	logic [dwpd_pkg::GAIN_W-1:0]        kd_gain_q;
	logic [dwpd_pkg::BAND_W-1:0]        done_band_q;
	logic [dwpd_pkg::SLEW_W-1:0]        slew_drop_q;
	logic signed [dwpd_pkg::DRV_W-1:0]  start_drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_deg_q  <= dwpd_pkg::RST_TARGET_DEG;
			kp_gain_q     <= dwpd_pkg::RST_KP_GAIN;
			kd_gain_q     <= dwpd_pkg::RST_KD_GAIN;
			done_band_q   <= dwpd_pkg::RST_DONE_BAND;
			slew_drop_q   <= dwpd_pkg::RST_SLEW_DROP;
			start_drive_q <= dwpd_pkg::RST_START_DRIVE;
		end else if (cfg_we) begin
			case (cfg_index)
				dwpd_pkg::REG_TARGET_DEG:  target_deg_q  <= cfg_data[dwpd_pkg::POS_W-1:0];
				dwpd_pkg::REG_KP_GAIN:     kp_gain_q     <= cfg_data[dwpd_pkg::GAIN_W-1:0];
				dwpd_pkg::REG_KD_GAIN:     kd_gain_q     <= cfg_data[dwpd_pkg::GAIN_W-1:0];
				dwpd_pkg::REG_DONE_BAND:   done_band_q   <= cfg_data[dwpd_pkg::BAND_W-1:0];
				dwpd_pkg::REG_SLEW_DROP:   slew_drop_q   <= cfg_data[dwpd_pkg::SLEW_W-1:0];
				dwpd_pkg::REG_START_DRIVE: start_drive_q <= cfg_data[dwpd_pkg::DRV_W-1:0];
				default: ; // unknown index: drop the write
			endcase
		end
	end

	// stage 0: side errors straight from the request payload
	logic signed [dwpd_pkg::ERR_W-1:0] err_l, err_r;

	dwpd_error u_err_l (
		.pos_a (in_ch.left_pos_a),
		.pos_b (in_ch.left_pos_b),
		.pos_c (in_ch.left_pos_c),
		.target(target_deg_q),
		.err   (err_l)
	);

	dwpd_error u_err_r (
		.pos_a (in_ch.right_pos_a),
		.pos_b (in_ch.right_pos_b),
		.pos_c (in_ch.right_pos_c),
		.target(target_deg_q),
		.err   (err_r)
	);

	// handshake: stage 1 advances whenever the result register is empty or draining
	logic valid_s1, out_valid_q, adv, in_ready;
	logic restart_s1;
	logic signed [dwpd_pkg::ERR_W-1:0] err_l_s1, err_r_s1;

	assign adv           = !out_valid_q || out_ch.ready;
	assign in_ready      = !valid_s1 || adv;
	assign in_ch.ready   = in_ready;
	assign out_ch.valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			restart_s1 <= in_ch.restart;
			err_l_s1   <= err_l;
			err_r_s1   <= err_r;
		end
	end

	// controller state
	logic signed [dwpd_pkg::DRV_W-1:0] prev_l_q, prev_r_q;
	logic signed [dwpd_pkg::ERR_W-1:0] last_l_q, last_r_q;
	logic                              first_q, finished_q;

	// state as seen by this sample: restart takes effect first
	logic signed [dwpd_pkg::DRV_W-1:0] prev_l, prev_r;
	logic signed [dwpd_pkg::ERR_W-1:0] last_l, last_r;
	logic                              first, finished;

	always_comb begin
		prev_l   = restart_s1 ? start_drive_q : prev_l_q;
		prev_r   = restart_s1 ? start_drive_q : prev_r_q;
		last_l   = restart_s1 ? '0 : last_l_q;
		last_r   = restart_s1 ? '0 : last_r_q;
		first    = restart_s1 ? 1'b1 : first_q;
		finished = restart_s1 ? 1'b0 : finished_q;
	end

	// arrival check: both error magnitudes strictly inside the band
	logic [dwpd_pkg::ERR_W-1:0] mag_l, mag_r;
	logic                       arrive;

	assign mag_l  = err_l_s1[dwpd_pkg::ERR_W-1] ? dwpd_pkg::ERR_W'(-err_l_s1)
	                                             : dwpd_pkg::ERR_W'(err_l_s1);
	assign mag_r  = err_r_s1[dwpd_pkg::ERR_W-1] ? dwpd_pkg::ERR_W'(-err_r_s1)
	                                             : dwpd_pkg::ERR_W'(err_r_s1);
	assign arrive = (mag_l < dwpd_pkg::ERR_W'(done_band_q)) &&
	                (mag_r < dwpd_pkg::ERR_W'(done_band_q));

	logic signed [dwpd_pkg::DRV_W-1:0] drv_l, drv_r;

	dwpd_side u_side_l (
		.err       (err_l_s1),
		.last_err  (last_l),
		.prev_drive(prev_l),
		.first     (first),
		.kp_gain   (kp_gain_q),
		.kd_gain   (kd_gain_q),
		.slew_drop (slew_drop_q),
		.drive     (drv_l)
	);

	dwpd_side u_side_r (
		.err       (err_r_s1),
		.last_err  (last_r),
		.prev_drive(prev_r),
		.first     (first),
		.kp_gain   (kp_gain_q),
		.kd_gain   (kd_gain_q),
		.slew_drop (slew_drop_q),
		.drive     (drv_r)
	);

	logic take_s1;
	assign take_s1 = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_l_q    <= dwpd_pkg::RST_START_DRIVE;
			prev_r_q    <= dwpd_pkg::RST_START_DRIVE;
			last_l_q    <= '0;
			last_r_q    <= '0;
			first_q     <= 1'b1;
			finished_q  <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (take_s1) begin
				if (finished || arrive) begin
					// hold the history, keeping any restart, and latch done
					prev_l_q   <= prev_l;
					prev_r_q   <= prev_r;
					last_l_q   <= last_l;
					last_r_q   <= last_r;
					first_q    <= first;
					finished_q <= 1'b1;
				end else begin
					// advance the history with this step
					prev_l_q   <= drv_l;
					prev_r_q   <= drv_r;
					last_l_q   <= err_l_s1;
					last_r_q   <= err_r_s1;
					first_q    <= 1'b0;
					finished_q <= 1'b0;
				end
			end
		end
	end

	// result register: zero drives and done once arrived
	logic signed [dwpd_pkg::DRV_W-1:0] left_drive_q, right_drive_q;
	logic                              done_q;

	always_ff @(posedge clk) begin
		if (take_s1) begin
			if (finished || arrive) begin
				left_drive_q  <= '0;
				right_drive_q <= '0;
				done_q        <= 1'b1;
			end else begin
				left_drive_q  <= drv_l;
				right_drive_q <= drv_r;
				done_q        <= 1'b0;
			end
		end
	end

	assign out_ch.left_drive  = left_drive_q;
	assign out_ch.right_drive = right_drive_q;
	assign out_ch.done_res    = done_q;
endmodule

// ===== sv/dwpd_error.sv =====
// Side error: target minus the truncated average of three encoder positions.
module dwpd_error (
	input  logic signed [dwpd_pkg::POS_W-1:0] pos_a,
	input  logic signed [dwpd_pkg::POS_W-1:0] pos_b,
	input  logic signed [dwpd_pkg::POS_W-1:0] pos_c,
	input  logic signed [dwpd_pkg::POS_W-1:0] target,
	output logic signed [dwpd_pkg::ERR_W-1:0] err
);
	// reciprocal of three, exact for magnitudes below 2^22
	localparam int MAG_W = 22;
	localparam int RSH   = 24;
	localparam int RCP_W = 23;
	localparam logic [RCP_W-1:0] RECIP3 = 23'd5592406;

	logic signed [dwpd_pkg::ERR_W-1:0] sum;
	logic [MAG_W-1:0]                  mag;
	logic [MAG_W+RCP_W-1:0]            prod;
	logic [MAG_W-1:0]                  quo;
	logic signed [dwpd_pkg::ERR_W-1:0] avg;

	assign sum  = dwpd_pkg::ERR_W'(pos_a) + dwpd_pkg::ERR_W'(pos_b) + dwpd_pkg::ERR_W'(pos_c);
	assign mag  = sum[dwpd_pkg::ERR_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
	assign prod = {{RCP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP3};
	assign quo  = MAG_W'(prod >> RSH);
	// truncate toward zero: divide the magnitude, then restore the sign
	assign avg  = sum[dwpd_pkg::ERR_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign err  = dwpd_pkg::ERR_W'(target) - avg;
endmodule

// ===== sv/dwpd_side.sv =====
// One side's PD term, saturation to 16 bits and drop-rate floor.
module dwpd_side (
	input  logic signed [dwpd_pkg::ERR_W-1:0]  err,
	input  logic signed [dwpd_pkg::ERR_W-1:0]  last_err,
	input  logic signed [dwpd_pkg::DRV_W-1:0]  prev_drive,
	input  logic                               first,
	input  logic [dwpd_pkg::GAIN_W-1:0]        kp_gain,
	input  logic [dwpd_pkg::GAIN_W-1:0]        kd_gain,
	input  logic [dwpd_pkg::SLEW_W-1:0]        slew_drop,
	output logic signed [dwpd_pkg::DRV_W-1:0]  drive
);
	localparam int DIF_W = dwpd_pkg::ERR_W + 1;
	localparam int PKP_W = dwpd_pkg::ERR_W + dwpd_pkg::GAIN_W + 1;
	localparam int PKD_W = DIF_W + dwpd_pkg::GAIN_W + 1;
	localparam int SUM_W = PKD_W + 1;
	localparam int SCL_W = SUM_W - 8;
	localparam int LO_W  = dwpd_pkg::DRV_W + 1;
	localparam logic signed [SCL_W-1:0] SAT_HI = SCL_W'(32767);
	localparam logic signed [SCL_W-1:0] SAT_LO = -SCL_W'(32768);

	logic signed [DIF_W-1:0]           diff;
	logic signed [PKP_W-1:0]           p_kp;
	logic signed [PKD_W-1:0]           p_kd;
	logic signed [SUM_W-1:0]           sum;
	logic signed [SCL_W-1:0]           scaled;
	logic signed [dwpd_pkg::DRV_W-1:0] sat;
	logic signed [LO_W-1:0]            lo;

	assign diff   = first ? '0 : (DIF_W'(err) - DIF_W'(last_err));
	assign p_kp   = PKP_W'(err) * $signed({1'b0, kp_gain});
	assign p_kd   = PKD_W'(diff) * $signed({1'b0, kd_gain});
	assign sum    = SUM_W'(p_kp) + SUM_W'(p_kd);
	// drop the fraction bits: floor toward minus infinity
	assign scaled = sum[SUM_W-1:8];
	assign lo     = LO_W'(prev_drive) - $signed({2'b00, slew_drop});

	always_comb begin
		if (scaled > SAT_HI) begin
			sat = 16'sh7FFF;
		end else if (scaled < SAT_LO) begin
			sat = 16'sh8000;
		end else begin
			sat = scaled[dwpd_pkg::DRV_W-1:0];
		end
		if (LO_W'(sat) < lo) begin
			drive = lo[dwpd_pkg::DRV_W-1:0];
		end else begin
			drive = sat;
		end
	end
endmodule

// ===== sv/dwpd_checker.sv =====
// Checker: port-level timing properties of the PD drive block, bound to the top level.
module dwpd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [dwpd_pkg::DRV_W-1:0]  left_drive,
	input logic signed [dwpd_pkg::DRV_W-1:0]  right_drive,
	input logic                               done_res
);
	// a stalled result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive) &&
		$stable(right_drive) && $stable(done_res))
		else $error("result changed while stalled");

	// with the result side free, the block always takes a request
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("request refused with a free result path");

	// an accepted request reaches out_valid through stage 1 when the result side drains
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("result missing after two cycles");

	// no result directly out of reset
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result valid right after reset");
endmodule

bind dual_wheel_pd_drive_slew dwpd_checker u_dwpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.left_drive (out_ch.left_drive),
	.right_drive(out_ch.right_drive),
	.done_res   (out_ch.done_res)
);

// ===== tb/sv/drive_checker.sv =====
// Drive checker: follows config writes and requests, predicts every drive result and compares it.
module drive_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dwpd_pkg::IDX_W-1:0] cfg_index,
	input  logic [dwpd_pkg::CFG_W-1:0] cfg_data,
	dwpd_in_if                         req_ch,
	dwpd_out_if                        res_ch,
	output int                         fail_count,
	output int                         outstanding
);
	import dwpd_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam longint DRIVE_MAX = (longint'(1) << (DRV_W - 1)) - 1;
	localparam longint DRIVE_MIN = -(longint'(1) << (DRV_W - 1));

	typedef struct packed {
		logic signed [DRV_W-1:0] left_drive;
		logic signed [DRV_W-1:0] right_drive;
		logic                    done;
	} drive_result_t;

	// shadow registers
	longint target_sh, kp_sh, kd_sh, band_sh, slew_sh, start_sh;
	// controller history
	longint prev_left, prev_right, last_err_left, last_err_right;
	bit     fresh_start, arrived;

	drive_result_t expected_drives[$];

	function automatic void restart_history();
		prev_left      = start_sh;
		prev_right     = start_sh;
		last_err_left  = 0;
		last_err_right = 0;
		fresh_start    = 1'b1;
		arrived        = 1'b0;
	endfunction

	// signed division truncates toward zero, as the average must
	function automatic longint side_error(logic signed [POS_W-1:0] a, b, c);
		longint sum;
		sum = longint'(a) + longint'(b) + longint'(c);
		return target_sh - sum / 3;
	endfunction

	function automatic longint limited_drive(longint err, longint last, longint prev);
		longint delta, v;
		delta = fresh_start ? 0 : err - last;
		v = (err * kp_sh + delta * kd_sh) >>> 8;
		if (v > DRIVE_MAX) v = DRIVE_MAX;
		if (v < DRIVE_MIN) v = DRIVE_MIN;
		if (v < prev - slew_sh) v = prev - slew_sh;
		return v;
	endfunction

	function automatic drive_result_t step_controller(logic restart,
			logic signed [POS_W-1:0] la, lb, lc, ra, rb, rc);
		longint el, er, dl, dr;
		drive_result_t r;
		r = '0;
		if (restart) restart_history();
		if (arrived) begin
			r.done = 1'b1;
			return r;
		end
		el = side_error(la, lb, lc);
		er = side_error(ra, rb, rc);
		if ((el < 0 ? -el : el) < band_sh && (er < 0 ? -er : er) < band_sh) begin
			arrived = 1'b1;
			r.done  = 1'b1;
			return r;
		end
		dl = limited_drive(el, last_err_left, prev_left);
		dr = limited_drive(er, last_err_right, prev_right);
		last_err_left  = el;
		last_err_right = er;
		prev_left      = dl;
		prev_right     = dr;
		fresh_start    = 1'b0;
		r.left_drive   = dl[DRV_W-1:0];
		r.right_drive  = dr[DRV_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_result_t want;
		if (!arst_n) begin
			target_sh = longint'(RST_TARGET_DEG);
			kp_sh     = RST_KP_GAIN;
			kd_sh     = RST_KD_GAIN;
			band_sh   = RST_DONE_BAND;
			slew_sh   = RST_SLEW_DROP;
			start_sh  = longint'(RST_START_DRIVE);
			restart_history();
			expected_drives.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET_DEG:  target_sh = longint'($signed(cfg_data[POS_W-1:0]));
					REG_KP_GAIN:     kp_sh     = cfg_data[GAIN_W-1:0];
					REG_KD_GAIN:     kd_sh     = cfg_data[GAIN_W-1:0];
					REG_DONE_BAND:   band_sh   = cfg_data[BAND_W-1:0];
					REG_SLEW_DROP:   slew_sh   = cfg_data[SLEW_W-1:0];
					REG_START_DRIVE: start_sh  = longint'($signed(cfg_data[DRV_W-1:0]));
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_drives.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("drive result with no request pending: left %0d right %0d done %0b",
							res_ch.left_drive, res_ch.right_drive, res_ch.done_res);
					fail_count++;
				end else begin
					want = expected_drives.pop_front();
					if (res_ch.left_drive !== want.left_drive
							|| res_ch.right_drive !== want.right_drive
							|| res_ch.done_res !== want.done) begin
						if (fail_count < REPORT_LIMIT)
							$display("drive mismatch: left %0d/%0d right %0d/%0d done %0b/%0b (exp/got)",
								want.left_drive, res_ch.left_drive,
								want.right_drive, res_ch.right_drive,
								want.done, res_ch.done_res);
						fail_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				expected_drives.push_back(step_controller(req_ch.restart,
					req_ch.left_pos_a, req_ch.left_pos_b, req_ch.left_pos_c,
					req_ch.right_pos_a, req_ch.right_pos_b, req_ch.right_pos_c));
			outstanding <= expected_drives.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: clock, reset, config phases, request stimulus and the final verdict.
module tb;
	import dwpd_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HEAVY_PCT       = 78;
	localparam int LIGHT_PCT       = 13;
	localparam longint POS_MAX     = (longint'(1) << (POS_W - 1)) - 1;
	localparam longint POS_MIN     = -(longint'(1) << (POS_W - 1));
	localparam longint DRIVE_MAX   = (longint'(1) << (DRV_W - 1)) - 1;
	localparam longint DRIVE_MIN   = -(longint'(1) << (DRV_W - 1));
	localparam longint GAIN_MAX    = (longint'(1) << GAIN_W) - 1;
	localparam longint BAND_MAX    = (longint'(1) << BAND_W) - 1;
	localparam longint SLEW_MAX    = (longint'(1) << SLEW_W) - 1;
	// indexes with no register behind them
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

	typedef struct packed {
		logic                    restart;
		logic signed [POS_W-1:0] left_a, left_b, left_c;
		logic signed [POS_W-1:0] right_a, right_b, right_c;
	} wheel_req_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int     fail_count;
	int     outstanding;
	int     cycle_count;
	int     src_idle_pct;
	int     sink_stall_pct;
	int     phase_sent;
	longint target_now;

	dwpd_in_if  req_ch ();
	dwpd_out_if res_ch ();

	dual_wheel_pd_drive_slew dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (req_ch),
		.out_ch    (res_ch)
	);

	drive_checker drive_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_ch      (req_ch),
		.res_ch      (res_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at random, count cycles and stop a hung run.
	always @(posedge clk) begin
		cycle_count    <= cycle_count + 1;
		res_ch.ready   <= ($urandom_range(99) >= sink_stall_pct);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[dual_wheel_pd_drive_slew] ERROR");
			$finish;
		end
	end

	// Write one register; junk above the register width must be ignored by the block.
	task automatic write_reg(logic [IDX_W-1:0] idx, longint value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic longint padded(longint value, int width);
		return (longint'($urandom) << width) | (value & ((longint'(1) << width) - 1));
	endfunction

	// Offer one request, idling before it at random, and hold it until accepted.
	// Lower valid only inside the idle loop so that back-to-back requests keep it high.
	task automatic send_request(wheel_req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.restart     <= r.restart;
		req_ch.left_pos_a  <= r.left_a;
		req_ch.left_pos_b  <= r.left_b;
		req_ch.left_pos_c  <= r.left_c;
		req_ch.right_pos_a <= r.right_a;
		req_ch.right_pos_b <= r.right_b;
		req_ch.right_pos_c <= r.right_c;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		phase_sent++;
	endtask

	task automatic send_positions(bit restart, longint la, lb, lc, ra, rb, rc);
		wheel_req_t r;
		r.restart = restart;
		r.left_a  = POS_W'(la);
		r.left_b  = POS_W'(lb);
		r.left_c  = POS_W'(lc);
		r.right_a = POS_W'(ra);
		r.right_b = POS_W'(rb);
		r.right_c = POS_W'(rc);
		send_request(r);
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [POS_W-1:0] jittered(longint center, int spread);
		longint p;
		p = center + longint'($urandom_range(2 * spread)) - spread;
		if (p > POS_MAX) p = POS_MAX;
		if (p < POS_MIN) p = POS_MIN;
		return p[POS_W-1:0];
	endfunction

	// Directed part with reset defaults: target 0, arrival band 13.
	task automatic run_directed();
		// extremes of every position, first sample so no derivative
		send_positions(1'b0, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
		send_positions(1'b0, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN);
		// error exactly at the band edge does not count as arrived
		send_positions(1'b0, 13, 13, 13, 0, 0, 0);
		send_positions(1'b0, 100, -100, 0, -2000, 1000, 500);
		send_positions(1'b0, POS_MAX, POS_MIN, 0, POS_MIN, POS_MAX, -1);
		// sum of -4 averages to -1 toward zero; both sides inside the band
		send_positions(1'b0, -1, -1, -2, 12, 12, 12);
		// latched arrival: drives stay zero whatever the positions
		send_positions(1'b0, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
		send_positions(1'b0, 5000, -7000, 123, 0, 0, 0);
		// arrival on the first sample after restart, -38 averages to -12
		send_positions(1'b1, 1, 1, 2, -12, -12, -14);
		send_positions(1'b1, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
		send_positions(1'b0, POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
		send_positions(1'b0, 20, 20, 20, -20, -20, -20);
		send_positions(1'b1, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, POS_MIN);
		send_positions(1'b0, 3000, 3000, 3000, 2999, 3001, 3000);
		send_positions(1'b0, -50, -60, -70, 40, 30, 20);
		send_positions(1'b0, 0, 0, 0, 0, 0, 0);
		send_positions(1'b0, 400, 400, 400, 400, 400, 400);
	endtask

	// Pick a setting per phase: two at the extremes, one at full gain, the rest random.
	task automatic configure_phase(int p);
		longint tgt, kp, kd, band, slew, start;
		case (p)
			1: begin
				tgt = POS_MAX; kp = GAIN_MAX; kd = GAIN_MAX;
				band = BAND_MAX; slew = 0; start = DRIVE_MAX;
			end
			2: begin
				tgt = POS_MIN; kp = 0; kd = 0;
				band = 0; slew = SLEW_MAX; start = DRIVE_MIN;
			end
			5: begin
				tgt = longint'($urandom_range(2000)) - 1000;
				kp = GAIN_MAX; kd = GAIN_MAX; band = $urandom_range(4, 60);
				slew = $urandom_range(300); start = DRIVE_MIN;
			end
			default: begin
				tgt   = longint'($urandom_range(1000000)) - 500000;
				kp    = $urandom_range(12000);
				kd    = $urandom_range(20000);
				band  = $urandom_range(4, 200);
				slew  = $urandom_range(SLEW_MAX);
				start = longint'($urandom_range(GAIN_MAX)) + DRIVE_MIN;
			end
		endcase
		target_now = tgt;
		if (p == 0) begin
			write_reg(REG_SPARE_LO, $urandom);
			write_reg(REG_SPARE_HI, $urandom);
		end
		write_reg(REG_TARGET_DEG, tgt);
		write_reg(REG_KP_GAIN, padded(kp, GAIN_W));
		write_reg(REG_KD_GAIN, padded(kd, GAIN_W));
		write_reg(REG_DONE_BAND, padded(band, BAND_W));
		write_reg(REG_SLEW_DROP, padded(slew, SLEW_W));
		write_reg(REG_START_DRIVE, padded(start, DRV_W));
	endtask

	// A move toward the target: usually a restart, errors decaying to zero with encoder
	// jitter, then a short tail that sits at the target once arrived.
	task automatic run_approach();
		int         steps, tail, spread, jit, remaining;
		longint     start_l, start_r, err_l, err_r;
		wheel_req_t r;
		steps = $urandom_range(3, 14);
		tail  = $urandom_range(3);
		jit   = $urandom_range(4);
		case ($urandom_range(2))
			0:       spread = 40;
			1:       spread = 3000;
			default: spread = 600000;
		endcase
		start_l = longint'($urandom_range(2 * spread)) - spread;
		start_r = longint'($urandom_range(2 * spread)) - spread;
		for (int k = 0; k < steps + tail; k++) begin
			remaining = steps - 1 - k;
			if (remaining < 0) remaining = 0;
			err_l = start_l * remaining / (steps - 1);
			err_r = start_r * remaining / (steps - 1);
			// now and then skip the restart to continue from the previous move
			r.restart = (k == 0) && ($urandom_range(99) < 85);
			r.left_a  = jittered(target_now - err_l, jit);
			r.left_b  = jittered(target_now - err_l, jit);
			r.left_c  = jittered(target_now - err_l, jit);
			r.right_a = jittered(target_now - err_r, jit);
			r.right_b = jittered(target_now - err_r, jit);
			r.right_c = jittered(target_now - err_r, jit);
			send_request(r);
		end
	endtask

	// Noise: every bit of every field at random.
	task automatic send_noise();
		wheel_req_t r;
		r.restart = ($urandom_range(99) < 20);
		r.left_a  = POS_W'($urandom);
		r.left_b  = POS_W'($urandom);
		r.left_c  = POS_W'($urandom);
		r.right_a = POS_W'($urandom);
		r.right_b = POS_W'($urandom);
		r.right_c = POS_W'($urandom);
		send_request(r);
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_SENDER:   begin src_idle_pct = HEAVY_PCT; sink_stall_pct = 0;         end
			IDLE_RECEIVER: begin src_idle_pct = 0;         sink_stall_pct = HEAVY_PCT; end
			IDLE_BOTH:     begin src_idle_pct = LIGHT_PCT; sink_stall_pct = LIGHT_PCT; end
			default:       begin src_idle_pct = 0;         sink_stall_pct = 0;         end
		endcase
	endtask

	initial begin
		// drive every block input to a known value before the first edge
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		req_ch.valid       = 1'b0;
		req_ch.restart     = 1'b0;
		req_ch.left_pos_a  = '0;
		req_ch.left_pos_b  = '0;
		req_ch.left_pos_c  = '0;
		req_ch.right_pos_a = '0;
		req_ch.right_pos_b = '0;
		req_ch.right_pos_c = '0;
		res_ch.ready       = 1'b0;
		src_idle_pct       = 0;
		sink_stall_pct     = 0;
		target_now         = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_idling(IDLE_NONE);
		run_directed();
		drain();

		// random phases; registers change only once the block has gone quiet
		for (int p = 0; p < PHASES; p++) begin
			set_idling(idle_mode_t'(p % 4));
			configure_phase(p);
			phase_sent = 0;
			while (phase_sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(9) < 8)
					run_approach();
				else
					send_noise();
			end
			drain();
		end

		if (fail_count == 0)
			$display("[dual_wheel_pd_drive_slew] OK");
		else
			$display("[dual_wheel_pd_drive_slew] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/dwpd_pkg.sv
sv/dwpd_if.sv
sv/dwpd_error.sv
sv/dwpd_side.sv
sv/dual_wheel_pd_drive_slew.sv
sv/dwpd_checker.sv
tb/sv/drive_checker.sv
tb/sv/tb.sv
